FILE: rtl/event_calendar_priority_queue_unit_assert.svh
// ============================================================================
// event calendar assertion macros
// shared concurrent assertion forms for the checker
// ============================================================================
`ifndef EVENT_CALENDAR_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define EVENT_CALENDAR_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// clocked check, masked while reset is asserted
`define ECPQ_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("event calendar check failed");

// clocked check, live during reset as well
`define ECPQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("event calendar check failed");

`endif

FILE: rtl/ecpq_pkg.sv
// ============================================================================
// ecpq_pkg
// types, codes and defaults shared by the event calendar files
// ============================================================================
`timescale 1ns / 1ps

package ecpq_pkg;

    localparam int ECPQ_DEPTH_DEFAULT = 16;
    localparam int ECPQ_TIME_W        = 32;
    localparam int ECPQ_KIND_W        = 4;
    localparam int ECPQ_INFO_W        = 16;
    localparam int ECPQ_STATUS_W      = 2;
    localparam int ECPQ_FILL_W        = 5;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // status codes
    localparam logic [ECPQ_STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [ECPQ_STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [ECPQ_STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                   cmd;
        logic [ECPQ_TIME_W-1:0] event_time;
        logic [ECPQ_KIND_W-1:0] event_kind;
        logic [ECPQ_INFO_W-1:0] event_info;
    } ecpq_cmd_t;

    typedef struct packed {
        logic [ECPQ_STATUS_W-1:0] status;
        logic                     out_valid;
        logic [ECPQ_TIME_W-1:0]   out_time;
        logic [ECPQ_KIND_W-1:0]   out_kind;
        logic [ECPQ_INFO_W-1:0]   out_info;
        logic [ECPQ_FILL_W-1:0]   fill;
    } ecpq_rsp_t;

    // one stored event
    typedef struct packed {
        logic [ECPQ_TIME_W-1:0] event_time;
        logic [ECPQ_KIND_W-1:0] event_kind;
        logic [ECPQ_INFO_W-1:0] event_info;
    } ecpq_entry_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic        insert;
        logic        pop;
        ecpq_entry_t new_entry;
    } ecpq_ctl_t;

endpackage

FILE: rtl/ecpq_cell.sv
// ============================================================================
// ecpq_cell
// one slot of the sorted chain: keeps, takes the new event or shifts
// ============================================================================
`timescale 1ns / 1ps

module ecpq_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                clk,
    input  ecpq_pkg::ecpq_ctl_t ctl,
    input  logic [CNT_W-1:0]    count,
    input  ecpq_pkg::ecpq_entry_t prev_entry,
    input  logic                prev_go,
    input  ecpq_pkg::ecpq_entry_t next_entry,
    output ecpq_pkg::ecpq_entry_t entry,
    output logic                go
);
    import ecpq_pkg::*;

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    ecpq_entry_t entry_reg;
    ecpq_entry_t entry_next;
    logic        occupied;
    logic        take_new;

    // held slots form a prefix of the chain
    assign occupied = IDX < count;
    // new event passes over every held event of equal or smaller time
    assign go       = occupied && (entry_reg.event_time <= ctl.new_entry.event_time);
    assign take_new = (INDEX == 0) || prev_go;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctl.pop)
        begin
            entry_next = next_entry;
        end
        else if (ctl.insert && !go)
        begin
            entry_next = take_new ? ctl.new_entry : prev_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: rtl/event_calendar_priority_queue_unit.sv
// ============================================================================
// event_calendar_priority_queue_unit
// stable time-ordered event calendar built as a chain of slot cells
// ============================================================================
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------
//  cmd     | in        | cmd_valid / cmd_ready | ecpq_cmd_t
//  rsp     | out       | rsp_valid / rsp_ready | ecpq_rsp_t
//
//  one command per cycle while cmd_ready is high: every cell compares its key
//  with the new key in parallel and shifts by one slot as the command is taken
//  one response beat per command, from a single output register, valid on
//  the cycle after the command beat is taken
//  cmd_ready drops only while that register holds an untaken beat
//  reset clears the fill count and the response valid flag; slot payload
//  and response payload are not reset, only slots below the fill count are
//  ever read
//
`timescale 1ns / 1ps

module event_calendar_priority_queue_unit #(
    parameter int DEPTH = ecpq_pkg::ECPQ_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ecpq_pkg::ecpq_cmd_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ecpq_pkg::ecpq_rsp_t rsp
);
    import ecpq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    ecpq_rsp_t        rsp_reg;
    ecpq_rsp_t        rsp_next;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    ecpq_ctl_t        ctl;

    ecpq_entry_t      cell_entry [DEPTH];
    logic             cell_go    [DEPTH];

    // a new beat can enter whenever the output register is free or draining
    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = cmd_valid && cmd_ready;

    assign is_full  = count_reg == FULL_COUNT;
    assign is_empty = count_reg == '0;

    // broadcast operation, rejected commands leave the chain untouched
    always_comb
    begin
        ctl.insert               = accept && (cmd.cmd == CMD_INSERT) && !is_full;
        ctl.pop                  = accept && (cmd.cmd == CMD_POP) && !is_empty;
        ctl.new_entry.event_time = cmd.event_time;
        ctl.new_entry.event_kind = cmd.event_kind;
        ctl.new_entry.event_info = cmd.event_info;
    end

    // slot chain, head at index zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ecpq_entry_t prev_entry;
        logic        prev_go;
        ecpq_entry_t next_entry;

        if (i == 0)
        begin : g_head
            assign prev_entry = '0;
            assign prev_go    = 1'b0;
        end
        else
        begin : g_body
            assign prev_entry = cell_entry[i-1];
            assign prev_go    = cell_go[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_entry = '0;
        end
        else
        begin : g_link
            assign next_entry = cell_entry[i+1];
        end

        ecpq_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count_reg),
            .prev_entry (prev_entry),
            .prev_go    (prev_go),
            .next_entry (next_entry),
            .entry      (cell_entry[i]),
            .go         (cell_go[i])
        );
    end

    // fill count
    always_comb
    begin
        count_next = count_reg;
        priority if (ctl.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // response beat: event from the head before the update, fill count after it
    always_comb
    begin
        rsp_next           = rsp_reg;
        rsp_valid_next     = rsp_valid_reg && !rsp_ready;
        if (accept)
        begin
            rsp_valid_next     = 1'b1;
            rsp_next.status    = STATUS_DONE;
            rsp_next.out_valid = 1'b0;
            rsp_next.out_time  = '0;
            rsp_next.out_kind  = '0;
            rsp_next.out_info  = '0;
            rsp_next.fill      = ECPQ_FILL_W'(count_next);
            unique case (cmd.cmd)
                CMD_INSERT:
                begin
                    if (is_full)
                    begin
                        rsp_next.status = STATUS_FULL;
                    end
                end
                CMD_POP:
                begin
                    if (is_empty)
                    begin
                        rsp_next.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        rsp_next.out_valid = 1'b1;
                        rsp_next.out_time  = cell_entry[0].event_time;
                        rsp_next.out_kind  = cell_entry[0].event_kind;
                        rsp_next.out_info  = cell_entry[0].event_info;
                    end
                end
                default:
                begin
                    rsp_next.status = STATUS_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/ecpq_checker.sv
// ============================================================================
// ecpq_checker
// port-level checks on the event calendar, bound to the top level
// ============================================================================
`timescale 1ns / 1ps
`include "event_calendar_priority_queue_unit_assert.svh"

module ecpq_checker #(
    parameter int DEPTH = ecpq_pkg::ECPQ_DEPTH_DEFAULT
) (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input ecpq_pkg::ecpq_cmd_t cmd,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input ecpq_pkg::ecpq_rsp_t rsp
);
    import ecpq_pkg::*;

    localparam int FILL_MAX = (1 << ECPQ_FILL_W) - 1;

    logic cmd_unused;
    assign cmd_unused = ^cmd;

    // every accepted command yields a beat on the next cycle
    `ECPQ_ASSERT_CLK(a_rsp_follows, clk, rst_n, (cmd_valid && cmd_ready) |=> rsp_valid)

    // with no beat pending, commands are never held off
    `ECPQ_ASSERT_ALWAYS(a_ready_when_free, clk, !rsp_valid |-> (cmd_ready || cmd_unused === 1'bx))

    // only a successful pop carries an event, failures carry zeros
    `ECPQ_ASSERT_CLK(a_event_only_on_pop, clk, rst_n, (rsp_valid && rsp.status != STATUS_DONE) |-> (!rsp.out_valid && rsp.out_time == '0 && rsp.out_kind == '0 && rsp.out_info == '0))

    // fill never reports more than the depth
    `ECPQ_ASSERT_CLK(a_fill_bound, clk, rst_n, rsp_valid |-> ((DEPTH > FILL_MAX) || (int'(rsp.fill) <= DEPTH)))

    // a stalled beat holds
    `ECPQ_ASSERT_CLK(a_rsp_hold, clk, rst_n, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))

endmodule

bind event_calendar_priority_queue_unit ecpq_checker #(.DEPTH(DEPTH)) u_ecpq_checker (.*);

FILE: dv/ecpq_calendar_checker.sv
// ============================================================================
// ecpq_calendar_checker
// tracks the event calendar beside the unit and checks every response beat
// ============================================================================
`timescale 1ns / 1ps

module ecpq_calendar_checker #(
    parameter int DEPTH = ecpq_pkg::ECPQ_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_ready,
    input  ecpq_pkg::ecpq_cmd_t cmd,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  ecpq_pkg::ecpq_rsp_t rsp,
    output int                  fail_count,
    output int                  awaited_count
);
    import ecpq_pkg::*;

    ecpq_entry_t held_events[$];
    ecpq_rsp_t   awaited_rsps[$];
    ecpq_rsp_t   want;
    ecpq_rsp_t   predicted;
    int          mismatches;

    // applies one command to the calendar copy and returns the response it gives
    function automatic ecpq_rsp_t apply_calendar_cmd(ecpq_cmd_t c);
        ecpq_rsp_t   r;
        ecpq_entry_t e;
        int          pos;
        r = '0;
        if (c.cmd == CMD_INSERT)
        begin
            if (held_events.size() >= DEPTH)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                // stable placement: after every held event with an equal or earlier time
                pos = 0;
                while (pos < held_events.size() && held_events[pos].event_time <= c.event_time)
                    pos++;
                e.event_time = c.event_time;
                e.event_kind = c.event_kind;
                e.event_info = c.event_info;
                held_events.insert(pos, e);
                r.status = STATUS_DONE;
            end
        end
        else if (held_events.size() == 0)
        begin
            r.status = STATUS_EMPTY;
        end
        else
        begin
            e = held_events[0];
            held_events.delete(0);
            r.status    = STATUS_DONE;
            r.out_valid = 1'b1;
            r.out_time  = e.event_time;
            r.out_kind  = e.event_kind;
            r.out_info  = e.event_info;
        end
        r.fill = ECPQ_FILL_W'(held_events.size());
        return r;
    endfunction

    function automatic bit field_matches(string field, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, exp_v, act_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_events.delete();
            awaited_rsps.delete();
            mismatches = 0;
            fail_count    <= 0;
            awaited_count <= 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                predicted = apply_calendar_cmd(cmd);
                awaited_rsps.insert(awaited_rsps.size(), predicted);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_rsps.size() == 0)
                begin
                    $display("%0t: response beat with nothing awaited, expected none, actual %p",
                             $time, rsp);
                    mismatches++;
                end
                else
                begin
                    want = awaited_rsps[0];
                    awaited_rsps.delete(0);
                    mismatches += !field_matches("status", 32'(want.status), 32'(rsp.status));
                    mismatches += !field_matches("out_valid", 32'(want.out_valid),
                                                 32'(rsp.out_valid));
                    mismatches += !field_matches("out_time", want.out_time, rsp.out_time);
                    mismatches += !field_matches("out_kind", 32'(want.out_kind),
                                                 32'(rsp.out_kind));
                    mismatches += !field_matches("out_info", 32'(want.out_info),
                                                 32'(rsp.out_info));
                    mismatches += !field_matches("fill", 32'(want.fill), 32'(rsp.fill));
                end
            end
            fail_count    <= mismatches;
            awaited_count <= awaited_rsps.size();
        end
    end

endmodule

FILE: dv/tb_event_calendar_priority_queue_unit.sv
// ============================================================================
// tb_event_calendar_priority_queue_unit
// drives insert and pop beats into the event calendar under varied idling
// and back-pressure; a side checker predicts each response and compares it
// ============================================================================
`timescale 1ns / 1ps

module tb_event_calendar_priority_queue_unit;
    import ecpq_pkg::*;

    localparam int CAL_DEPTH    = ECPQ_DEPTH_DEFAULT;
    localparam int PHASE_ITEMS  = 584;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_ready;
    ecpq_cmd_t cmd;
    logic      rsp_valid;
    logic      rsp_ready;
    ecpq_rsp_t rsp;

    int fail_count;
    int awaited_count;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    bit hold_done;

    event_calendar_priority_queue_unit #(
        .DEPTH (CAL_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    ecpq_calendar_checker #(
        .DEPTH (CAL_DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .awaited_count (awaited_count)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run guard: a hung handshake or a lost beat ends here
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // receiver side: per-cycle random ready, or one long hold-off on request
    // so the output register stays full and cmd_ready is forced low
    initial
    begin
        rsp_ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // time keys: a mix that gives many ties, both ends of the range and
    // fully random values so every bit toggles
    function automatic logic [ECPQ_TIME_W-1:0] pick_event_time();
        case ($urandom_range(0, 5))
            0: return ECPQ_TIME_W'($urandom_range(0, 7));
            1: return 32'hFFFF_FFF8 + ECPQ_TIME_W'($urandom_range(0, 7));
            2: return {16'($urandom_range(0, 3)), 16'h0000};
            default: return $urandom();
        endcase
    endfunction

    // offers one command beat, after idle cycles drawn one by one at the
    // sender's idle rate; valid is held with a steady payload until taken
    task automatic send_cmd(input logic op, input logic [ECPQ_TIME_W-1:0] t,
                            input logic [ECPQ_KIND_W-1:0] k,
                            input logic [ECPQ_INFO_W-1:0] a);
        ecpq_cmd_t c;
        c.cmd        = op;
        c.event_time = t;
        c.event_kind = k;
        c.event_info = a;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_ready !== 1'b1) @(posedge clk);
    endtask

    // bursts leaning towards insert or pop, so the calendar swings between
    // empty and full many times; pops carry random, ignored payload
    task automatic run_random_mix(input int count);
        int issued;
        int burst;
        int insert_pct;
        issued = 0;
        while (issued < count)
        begin
            burst = $urandom_range(1, 40);
            case ($urandom_range(0, 2))
                0: insert_pct = 85;
                1: insert_pct = 15;
                default: insert_pct = 50;
            endcase
            repeat (burst)
            begin
                send_cmd(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_POP,
                         pick_event_time(), ECPQ_KIND_W'($urandom()),
                         ECPQ_INFO_W'($urandom()));
                issued++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd           = '0;
        hold_req      = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 88;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: pop on an empty calendar, with all payload bits set
        send_cmd(CMD_POP, 32'hFFFF_FFFF, 4'hF, 16'hFFFF);
        // extremes of the key and payload
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 4'hF, 16'hFFFF);
        send_cmd(CMD_INSERT, 32'h0000_0000, 4'h0, 16'h0000);
        // equal keys must leave in arrival order
        for (int k = 0; k < 3; k++)
            send_cmd(CMD_INSERT, 32'h0001_8000, ECPQ_KIND_W'(k + 1), 16'h1000 + 16'(k));
        // a tie at the top of the range, then fill up to depth
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 4'h5, 16'h5A5A);
        for (int k = 0; k < CAL_DEPTH - 6; k++)
            send_cmd(CMD_INSERT, pick_event_time(), ECPQ_KIND_W'($urandom()),
                     ECPQ_INFO_W'($urandom()));
        // insert into a full calendar is rejected
        send_cmd(CMD_INSERT, 32'h0000_0001, 4'hA, 16'hBEEF);
        // pops drain the head in time order
        repeat (6) send_cmd(CMD_POP, $urandom(), ECPQ_KIND_W'($urandom()),
                            ECPQ_INFO_W'($urandom()));

        // phase one: sender mostly busy, receiver mostly stalled
        run_random_mix(PHASE_ITEMS);

        // phase two: the other way round
        send_idle_pct = 88;
        recv_idle_pct = 10;
        run_random_mix(PHASE_ITEMS);

        // phase three: no idling, opened by a long receiver hold-off while
        // the sender keeps offering beats
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        run_random_mix(PHASE_ITEMS);

        cmd_valid <= 1'b0;
        // let the last accepted beat reach the awaited count
        @(posedge clk);

        // drain, then wait on to catch any stray response beat
        while (awaited_count != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
